FILE: src/record_list_length_checker_macros.svh
// assertion helpers shared by the checker modules
`ifndef RECORD_LIST_LENGTH_CHECKER_MACROS_SVH
`define RECORD_LIST_LENGTH_CHECKER_MACROS_SVH

// same-cycle implication, checked outside reset
`define RLLC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define RLLC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/rllc_pkg.sv
package rllc_pkg;

   // framing limits
   localparam int unsigned MaxRecords  = 1024;
   localparam int unsigned CountBytes  = 4;
   localparam int unsigned HeaderBytes = 8;

   localparam logic [31:0] MaxTotalReset = 32'd4194304;

   // framing phase codes
   localparam logic [1:0] PhCount   = 2'd0;
   localparam logic [1:0] PhHeader  = 2'd1;
   localparam logic [1:0] PhPayload = 2'd2;
   localparam logic [1:0] PhDone    = 2'd3;

   // verdict codes
   localparam logic [2:0] VerdictOk       = 3'd0;
   localparam logic [2:0] VerdictRange    = 3'd1;
   localparam logic [2:0] VerdictRecords  = 3'd2;
   localparam logic [2:0] VerdictHeader   = 3'd3;
   localparam logic [2:0] VerdictPayload  = 3'd4;
   localparam logic [2:0] VerdictTrailing = 3'd5;

   // one byte leaving the input register into the framing logic
   typedef struct packed {
      logic       valid;
      logic       last;
      logic [7:0] data;
   } step_type;

endpackage

FILE: src/rllc_frame.sv
`include "record_list_length_checker_macros.svh"

module rllc_frame (
   input  logic               clock,
   input  logic               reset,
   input  rllc_pkg::step_type step,
   input  logic [31:0]        max_total,
   output logic [2:0]         verdict
);

   logic [1:0]  phase_ff, phase_in;
   logic [31:0] total_ff, total_in;
   logic        over_ff, over_in;
   logic [31:0] shift_ff, shift_in;
   logic [2:0]  idx_ff, idx_in;
   logic [10:0] records_ff, records_in;
   logic [31:0] payload_ff, payload_in;
   logic [2:0]  error_ff, error_in;

   logic [31:0] shifted;
   logic [10:0] records_dec;
   logic [31:0] payload_dec;

   always_comb begin
      shifted     = {shift_ff[23:0], step.data};
      records_dec = records_ff - 11'd1;
      payload_dec = payload_ff - 32'd1;

      phase_in   = phase_ff;
      total_in   = total_ff;
      over_in    = over_ff;
      shift_in   = shift_ff;
      idx_in     = idx_ff;
      records_in = records_ff;
      payload_in = payload_ff;
      error_in   = error_ff;
      verdict    = rllc_pkg::VerdictOk;

      if (step.valid) begin
         over_in  = over_ff | (total_ff == '1);
         total_in = total_ff + 32'd1;

         if (error_ff == rllc_pkg::VerdictOk) begin
            unique case (phase_ff)
               rllc_pkg::PhCount: begin
                  shift_in = shifted;
                  idx_in   = idx_ff + 3'd1;
                  if (idx_ff == 3'(rllc_pkg::CountBytes - 1)) begin
                     idx_in   = '0;
                     shift_in = '0;
                     if (shifted > 32'(rllc_pkg::MaxRecords)) begin
                        error_in = rllc_pkg::VerdictRecords;
                     end else begin
                        records_in = shifted[10:0];
                        phase_in   = (shifted == '0) ? rllc_pkg::PhDone : rllc_pkg::PhHeader;
                     end
                  end
               end
               rllc_pkg::PhHeader: begin
                  shift_in = shifted;
                  idx_in   = idx_ff + 3'd1;
                  if (idx_ff == 3'(rllc_pkg::HeaderBytes - 1)) begin
                     // length word is the last four header bytes
                     payload_in = shifted;
                     shift_in   = '0;
                     if (shifted == '0) begin
                        records_in = records_dec;
                        phase_in   = (records_dec == '0) ? rllc_pkg::PhDone
                                                         : rllc_pkg::PhHeader;
                     end else begin
                        phase_in = rllc_pkg::PhPayload;
                     end
                  end
               end
               rllc_pkg::PhPayload: begin
                  payload_in = payload_dec;
                  if (payload_dec == '0) begin
                     records_in = records_dec;
                     phase_in   = (records_dec == '0) ? rllc_pkg::PhDone
                                                      : rllc_pkg::PhHeader;
                  end
               end
               default: begin
                  error_in = rllc_pkg::VerdictTrailing;
               end
            endcase
         end

         if (over_in || (total_in < 32'(rllc_pkg::CountBytes)) || (total_in > max_total)) begin
            verdict = rllc_pkg::VerdictRange;
         end else if (error_in != rllc_pkg::VerdictOk) begin
            verdict = error_in;
         end else if (phase_in == rllc_pkg::PhPayload) begin
            verdict = rllc_pkg::VerdictPayload;
         end else if (phase_in == rllc_pkg::PhHeader) begin
            verdict = rllc_pkg::VerdictHeader;
         end else if (phase_in == rllc_pkg::PhCount) begin
            verdict = rllc_pkg::VerdictRange;
         end else begin
            verdict = rllc_pkg::VerdictOk;
         end

         // list closed: back to the start state
         if (step.last) begin
            phase_in   = rllc_pkg::PhCount;
            total_in   = '0;
            over_in    = 1'b0;
            shift_in   = '0;
            idx_in     = '0;
            records_in = '0;
            payload_in = '0;
            error_in   = rllc_pkg::VerdictOk;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= rllc_pkg::PhCount;
         total_ff   <= '0;
         over_ff    <= 1'b0;
         shift_ff   <= '0;
         idx_ff     <= '0;
         records_ff <= '0;
         payload_ff <= '0;
         error_ff   <= rllc_pkg::VerdictOk;
      end else begin
         phase_ff   <= phase_in;
         total_ff   <= total_in;
         over_ff    <= over_in;
         shift_ff   <= shift_in;
         idx_ff     <= idx_in;
         records_ff <= records_in;
         payload_ff <= payload_in;
         error_ff   <= error_in;
      end
   end

   `RLLC_ASSERT_NOW(a_records_bound, 1'b1, records_ff <= 11'(rllc_pkg::MaxRecords), "records over limit")
   `RLLC_ASSERT_NOW(a_header_owed, phase_ff == rllc_pkg::PhHeader, records_ff != '0, "header with no records left")
   `RLLC_ASSERT_NOW(a_payload_owed, phase_ff == rllc_pkg::PhPayload, payload_ff != '0, "payload phase with zero left")
   `RLLC_ASSERT_NEXT(a_close_clears, step.valid && step.last, (total_ff == '0) && (phase_ff == rllc_pkg::PhCount), "state not cleared after last byte")

endmodule

FILE: src/record_list_length_checker.sv
// channel   | direction | ports                                  | transfer
// ----------+-----------+----------------------------------------+-------------------------
// req       | in        | req_valid, req_ready, req_data_byte,   | one list byte
//           |           | req_last_byte                          |
// rsp       | out       | rsp_valid, rsp_ready, rsp_verdict      | one verdict per list
// csr       | in        | csr_valid, csr_ready, csr_max_total_bytes | max total length write
//
// one byte per cycle sustained while no last byte is stalled: each byte passes through the input register,
// the framing update and verdict sit between that register and the verdict register
// a verdict is registered when its last byte leaves the input register and waits in its register
// bytes that close no list keep flowing while a verdict waits; a last byte stalls
// only while the previous verdict is still untaken
// synchronous active-high reset clears the framing state and sets the limit to 4 MiB
// csr writes are always taken (csr_ready is tied high)

`include "record_list_length_checker_macros.svh"

module record_list_length_checker (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_verdict,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_max_total_bytes
);

   // configuration register
   logic [31:0] max_total_ff, max_total_in;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_data_ff;
   logic        in_last_ff;

   // verdict register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_verdict_ff;

   logic               req_xfer;
   logic               advance;
   rllc_pkg::step_type step;
   logic [2:0]         verdict;

   assign csr_ready = 1'b1;
   assign max_total_in = (csr_valid && csr_ready) ? csr_max_total_bytes : max_total_ff;

   // a held byte moves on unless it closes a list and the verdict slot is busy
   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (advance && in_last_ff) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   assign step.valid = advance;
   assign step.last  = in_last_ff;
   assign step.data  = in_data_ff;

   rllc_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .max_total (max_total_ff),
      .verdict   (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_total_ff <= rllc_pkg::MaxTotalReset;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_total_ff <= max_total_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance && in_last_ff) begin
         rsp_verdict_ff <= verdict;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

   `RLLC_ASSERT_NOW(a_last_stalls, in_valid_ff && in_last_ff && rsp_valid_ff && !rsp_ready, !req_ready, "last byte passed a busy verdict slot")
   `RLLC_ASSERT_NEXT(a_verdict_follows, advance && in_last_ff, rsp_valid_ff, "verdict missing after last byte")
   `RLLC_ASSERT_NOW(a_verdict_code, rsp_valid_ff, rsp_verdict_ff <= rllc_pkg::VerdictTrailing, "verdict code out of range")

endmodule

FILE: sim/tb_record_list_length_checker.sv
`timescale 1ns / 100ps

module tb_record_list_length_checker;

   // generous watchdog bound on the whole run
   localparam int CycleLimit  = 400000;
   // random byte budget, spread over the limit settings below
   localparam int RandomBytes = 560;
   localparam int LimitSteps  = 6;

   // tracks the framing of the list in flight and owes one verdict per closed list
   class list_verdict_board;
      logic [31:0] byte_limit;
      logic [1:0]  phase;
      logic [31:0] total_seen;
      logic        length_over;
      logic [31:0] field_shift;
      logic [2:0]  field_byte_index;
      logic [10:0] records_left;
      logic [31:0] payload_left;
      logic [2:0]  first_error;
      logic [2:0]  verdicts_owed[$];
      int          fault_count;

      function new();
         byte_limit  = rllc_pkg::MaxTotalReset;
         fault_count = 0;
         clear_list();
      endfunction

      function void clear_list();
         phase            = rllc_pkg::PhCount;
         total_seen       = '0;
         length_over      = 1'b0;
         field_shift      = '0;
         field_byte_index = '0;
         records_left     = '0;
         payload_left     = '0;
         first_error      = rllc_pkg::VerdictOk;
      endfunction

      function void close_record();
         records_left = records_left - 11'd1;
         phase        = (records_left == 0) ? rllc_pkg::PhDone : rllc_pkg::PhHeader;
      endfunction

      // one byte transfer taken by the block
      function void note_transfer(input logic [7:0] data, input logic last);
         logic [2:0] want;
         if (total_seen == 32'hFFFF_FFFF) length_over = 1'b1;
         total_seen = total_seen + 32'd1;
         if (first_error == rllc_pkg::VerdictOk) begin
            case (phase)
               rllc_pkg::PhCount: begin
                  field_shift      = {field_shift[23:0], data};
                  field_byte_index = field_byte_index + 3'd1;
                  if (field_byte_index == rllc_pkg::CountBytes) begin
                     field_byte_index = '0;
                     if (field_shift > rllc_pkg::MaxRecords) begin
                        first_error = rllc_pkg::VerdictRecords;
                     end else begin
                        records_left = field_shift[10:0];
                        phase        = (records_left == 0) ? rllc_pkg::PhDone
                                                           : rllc_pkg::PhHeader;
                     end
                     field_shift = '0;
                  end
               end
               rllc_pkg::PhHeader: begin
                  field_shift      = {field_shift[23:0], data};
                  field_byte_index = field_byte_index + 3'd1;
                  if (field_byte_index == 0) begin
                     payload_left = field_shift;
                     field_shift  = '0;
                     if (payload_left == 0) close_record();
                     else phase = rllc_pkg::PhPayload;
                  end
               end
               rllc_pkg::PhPayload: begin
                  payload_left = payload_left - 32'd1;
                  if (payload_left == 0) close_record();
               end
               default: begin
                  first_error = rllc_pkg::VerdictTrailing;
               end
            endcase
         end
         if (last) begin
            if (length_over || total_seen < rllc_pkg::CountBytes
                || total_seen > byte_limit) begin
               want = rllc_pkg::VerdictRange;
            end else if (first_error != rllc_pkg::VerdictOk) begin
               want = first_error;
            end else begin
               case (phase)
                  rllc_pkg::PhPayload: want = rllc_pkg::VerdictPayload;
                  rllc_pkg::PhHeader:  want = rllc_pkg::VerdictHeader;
                  rllc_pkg::PhCount:   want = rllc_pkg::VerdictRange;
                  default:             want = rllc_pkg::VerdictOk;
               endcase
            end
            verdicts_owed = {verdicts_owed, want};
            clear_list();
         end
      endfunction

      task report(input string msg);
         $display("mismatch: %s", msg);
         fault_count++;
      endtask

      // one verdict transfer taken from the block
      task check_verdict(input logic [2:0] got);
         logic [2:0] want;
         if (verdicts_owed.size() == 0) begin
            report($sformatf("verdict %0d with no list closed", got));
         end else begin
            want = verdicts_owed.pop_front();
            if (got !== want)
               report($sformatf("verdict %0d, expected %0d", got, want));
         end
      endtask
   endclass

   // every input known from time zero
   logic        clock               = 1'b0;
   logic        reset               = 1'b1;
   logic        req_valid           = 1'b0;
   logic [7:0]  req_data_byte       = '0;
   logic        req_last_byte       = 1'b0;
   logic        rsp_ready           = 1'b1;
   logic        csr_valid           = 1'b0;
   logic [31:0] csr_max_total_bytes = '0;
   logic        req_ready;
   logic        rsp_valid;
   logic [2:0]  rsp_verdict;
   logic        csr_ready;

   list_verdict_board board;
   logic [7:0]        list_bytes[$];
   bit                gaps_on     = 1'b1;
   int                cycle_count = 0;

   record_list_length_checker uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_last_byte       (req_last_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_verdict         (rsp_verdict),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_max_total_bytes (csr_max_total_bytes)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // all block outputs change by nonblocking update, so at the edge we see pre-edge values
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_verdict(rsp_verdict);
   end

   // receiver stalls in random bursts, none once gaps are switched off
   initial begin
      forever begin
         @(posedge clock);
         if (gaps_on && !reset && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // one byte onto the end of the list under construction
   function automatic void append_byte(input logic [7:0] value);
      list_bytes = {list_bytes, value};
   endfunction

   // big-endian word onto the list under construction
   function automatic void push_word(input logic [31:0] word);
      for (int i = 3; i >= 0; i--) append_byte(word[8*i +: 8]);
   endfunction

   // one byte transfer; valid may drop for a burst before it, never while waiting
   task automatic send_byte(input logic [7:0] data, input logic last);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_transfer(data, last);
   endtask

   // last flag rides on the final byte only
   task automatic send_list();
      foreach (list_bytes[i]) send_byte(list_bytes[i], i == list_bytes.size() - 1);
   endtask

   // hold off until every verdict is back, then let the pipeline empty
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (board.verdicts_owed.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [31:0] value);
      csr_valid           <= 1'b1;
      csr_max_total_bytes <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid        <= 1'b0;
      board.byte_limit  = value;
   endtask

   // over a third well-formed lists with random content, the rest broken or noise
   function automatic void build_random_list();
      int kind;
      int records;
      int len;
      int cut;
      kind = $urandom_range(0, 99);
      list_bytes.delete();
      if (kind < 60) begin
         records = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
         push_word(records);
         repeat (records) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
            push_word($urandom());
            push_word(len);
            repeat (len) append_byte(8'($urandom_range(0, 255)));
         end
         if (kind >= 36 && kind < 45) begin
            // cut short anywhere, count field included
            cut = $urandom_range(1, list_bytes.size() - 1);
            while (list_bytes.size() > cut) void'(list_bytes.pop_back());
         end else if (kind >= 45 && kind < 54) begin
            // bytes after the last record
            repeat ($urandom_range(1, 4)) append_byte(8'($urandom_range(0, 255)));
         end else if (kind >= 54) begin
            list_bytes[$urandom_range(0, list_bytes.size() - 1)] = 8'($urandom_range(0, 255));
         end
      end else if (kind < 72) begin
         // record count past the ceiling
         push_word($urandom_range(rllc_pkg::MaxRecords + 1, 32'hFFFF_FFFF));
         repeat ($urandom_range(0, 6)) append_byte(8'($urandom_range(0, 255)));
      end else if (kind < 80) begin
         // legal count, far fewer records than promised
         push_word($urandom_range(4, rllc_pkg::MaxRecords));
         repeat ($urandom_range(0, 12)) append_byte(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 12)) append_byte(8'($urandom_range(0, 255)));
      end
   endfunction

   initial begin
      logic [31:0] limits[LimitSteps];
      int          bytes_in_step;
      board = new();
      limits[0] = rllc_pkg::MaxTotalReset;
      limits[1] = 32'd4;
      limits[2] = 32'hFFFF_FFFF;
      limits[3] = $urandom_range(8, 60);
      limits[4] = $urandom_range(61, 400);
      limits[5] = rllc_pkg::MaxTotalReset;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // too short for a count field
      list_bytes = '{8'hFF};
      send_list();
      // empty list, accepted
      list_bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
      send_list();
      // count at the ceiling, ends exactly on a record boundary
      list_bytes = '{8'h00, 8'h00, 8'h04, 8'h00};
      send_list();
      // count one past the ceiling
      list_bytes = '{8'h00, 8'h00, 8'h04, 8'h01};
      send_list();
      // empty list with one byte too many
      list_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
      send_list();
      // one record owed two payload bytes, only one arrives
      list_bytes.delete();
      push_word(32'd1);
      push_word(32'hA5A5_5A5A);
      push_word(32'd2);
      append_byte(8'h3C);
      send_list();

      // random lists under each limit setting; the last setting runs without gaps
      for (int s = 0; s < LimitSteps; s++) begin
         if (s > 0) begin
            drain_and_settle();
            write_limit(limits[s]);
         end
         if (s == LimitSteps - 1) gaps_on = 1'b0;
         bytes_in_step = 0;
         while (bytes_in_step < RandomBytes / LimitSteps) begin
            build_random_list();
            bytes_in_step += list_bytes.size();
            send_list();
         end
      end

      req_valid <= 1'b0;
      while (board.verdicts_owed.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.fault_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
